FILE: rtl/tmf_pkg.sv
package tmf_pkg;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_SIDE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILESET_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILES_PER_ROW = 2'd2;

   localparam logic [0:0] KIND_LOAD = 1'b0;
   localparam logic [0:0] KIND_MAP  = 1'b1;

   localparam int RGB_W   = 24;
   localparam int INDEX_W = 7;

endpackage

FILE: rtl/tile_match_finder_top.sv
// Tile match finder. A load item (kind 0) writes one in-range pixel into the
// tileset store; busy stays low. A map pixel (kind 1) is compared with the
// same position of every active tile (tileset_count, capped at MAX_TILES), one
// store read per tile through the single read port, so busy is high after the
// transfer while the reads run (not at all when no tile is active, or when an
// out-of-range pixel does not close its tile). On the closing pixel the
// result appears, one cycle wide on rsp_valid, in the first cycle with busy low
// again, or in the cycle after the transfer when no scan runs. The receiver cannot
// stall: every result must be taken in the cycle it is shown. Registers must be
// written by the user only while busy is low; the block does not enforce it.
module tile_match_finder_top #(
   parameter int MAX_TILES     = 128,
   parameter int MAX_TILE_SIDE = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [6:0]                          req_tile_index,
   input  logic [3:0]                          req_pixel_x,
   input  logic [3:0]                          req_pixel_y,
   input  logic [tmf_pkg::RGB_W-1:0]           req_rgb,
   input  logic                                req_last_pixel,

   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [tmf_pkg::INDEX_W-1:0]         rsp_match_index,
   output logic                                rsp_row_end,

   input  logic                                csr_we,
   input  logic [tmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tmf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TS2   = MAX_TILE_SIDE * MAX_TILE_SIDE;
   localparam int DEPTH = MAX_TILES * TS2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(MAX_TILES + 1);
   localparam int CNTW  = (NW > 8) ? NW : 8;
   localparam int IW    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

   // config
   logic [4:0]  tile_side_ff, tile_side_in;
   logic [7:0]  tileset_count_ff, tileset_count_in;
   logic [9:0]  tiles_per_row_ff, tiles_per_row_in;

   // control
   tmf_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]  iss_ff, iss_in;
   logic [AW-1:0]    iss_addr_ff, iss_addr_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [CNTW-1:0]  chk_idx_ff, chk_idx_in;
   logic [CNTW-1:0]  nt_ff, nt_in;
   logic             posok_ff, posok_in;
   logic             last_ff, last_in;
   logic [tmf_pkg::RGB_W-1:0] rgb_ff, rgb_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [MAX_TILES-1:0] cand_ff, cand_in;
   logic [9:0]       col_ff, col_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [tmf_pkg::INDEX_W-1:0] rsp_match_index_ff, rsp_match_index_in;
   logic             rsp_row_end_ff, rsp_row_end_in;

   // datapath
   logic             accept;
   logic [CNTW-1:0]  count_ext;
   logic [CNTW-1:0]  n_active;
   logic             pos_ok;
   logic             tile_ok;
   logic [AW-1:0]    base_addr;
   logic [AW-1:0]    wr_addr;
   logic             ram_we;
   logic [tmf_pkg::RGB_W-1:0] rd_data;
   logic [IW-1:0]    ci;
   logic             keep;
   logic             close;
   logic             close_found;
   logic [IW-1:0]    close_idx;
   logic [9:0]       row_width;
   logic [10:0]      col_next;

   assign accept    = start && (state_ff == tmf_pkg::ST_IDLE);
   assign busy      = (state_ff != tmf_pkg::ST_IDLE);
   assign count_ext = CNTW'(tileset_count_ff);
   assign n_active  = (count_ext > CNTW'(MAX_TILES)) ? CNTW'(MAX_TILES) : count_ext;
   assign pos_ok    = ({1'b0, req_pixel_x} < tile_side_ff) && ({1'b0, req_pixel_y} < tile_side_ff)
                      && ({3'b0, req_pixel_x} < 7'(MAX_TILE_SIDE))
                      && ({3'b0, req_pixel_y} < 7'(MAX_TILE_SIDE));
   assign tile_ok   = CNTW'(req_tile_index) < CNTW'(MAX_TILES);
   assign base_addr = pos_ok ? AW'(32'(req_pixel_y) * 32'(MAX_TILE_SIDE) + 32'(req_pixel_x))
                             : '0;
   assign wr_addr   = AW'(32'(req_tile_index) * 32'(TS2) + 32'(base_addr));
   assign ram_we    = accept && (req_kind == tmf_pkg::KIND_LOAD) && pos_ok && tile_ok;

   tmf_ram #(
      .WIDTH (tmf_pkg::RGB_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (req_rgb),
      .raddr (iss_addr_ff),
      .rdata (rd_data)
   );

   assign ci        = chk_idx_ff[IW-1:0];
   assign keep      = cand_ff[ci] && (!posok_ff || (rd_data == rgb_ff));
   assign row_width = (tiles_per_row_ff == 10'd0) ? 10'd1 : tiles_per_row_ff;
   assign col_next  = {1'b0, col_ff} + 11'd1;

   always_comb begin
      tile_side_in     = tile_side_ff;
      tileset_count_in = tileset_count_ff;
      tiles_per_row_in = tiles_per_row_ff;
      if (csr_we) begin
         unique case (csr_index)
            tmf_pkg::CSR_TILE_SIDE:     tile_side_in     = csr_wdata[4:0];
            tmf_pkg::CSR_TILESET_COUNT: tileset_count_in = csr_wdata[7:0];
            tmf_pkg::CSR_TILES_PER_ROW: tiles_per_row_in = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      iss_addr_in  = iss_addr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      nt_in        = nt_ff;
      posok_in     = posok_ff;
      last_in      = last_ff;
      rgb_in       = rgb_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      cand_in      = cand_ff;
      col_in       = col_ff;
      close        = 1'b0;
      close_found  = 1'b0;
      close_idx    = '0;

      unique case (state_ff)
         tmf_pkg::ST_IDLE: begin
            if (accept && (req_kind == tmf_pkg::KIND_MAP)) begin
               if ((n_active == '0) || (!pos_ok && !req_last_pixel)) begin
                  close = req_last_pixel;
               end else begin
                  state_in    = tmf_pkg::ST_SCAN;
                  iss_in      = '0;
                  iss_addr_in = base_addr;
                  nt_in       = n_active;
                  posok_in    = pos_ok;
                  last_in     = req_last_pixel;
                  rgb_in      = req_rgb;
                  found_in    = 1'b0;
               end
            end
         end
         tmf_pkg::ST_SCAN: begin
            if (iss_ff < nt_ff) begin
               iss_in       = iss_ff + 1'b1;
               iss_addr_in  = iss_addr_ff + AW'(TS2);
               chk_valid_in = 1'b1;
               chk_idx_in   = iss_ff;
            end
            if (chk_valid_ff) begin
               cand_in[ci] = keep;
               if (keep && !found_ff) begin
                  found_in = 1'b1;
                  idx_in   = ci;
               end
               if (chk_idx_ff == nt_ff - 1'b1) begin
                  state_in    = tmf_pkg::ST_IDLE;
                  close       = last_ff;
                  close_found = found_ff || keep;
                  close_idx   = found_ff ? idx_ff : ci;
               end
            end
         end
         default: state_in = tmf_pkg::ST_IDLE;
      endcase

      rsp_valid_in       = close;
      rsp_found_in       = close_found;
      rsp_match_index_in = close_found ? tmf_pkg::INDEX_W'(close_idx) : '0;
      rsp_row_end_in     = 1'b0;
      if (close) begin
         cand_in = '1;
         if (col_next >= {1'b0, row_width}) begin
            rsp_row_end_in = 1'b1;
            col_in         = '0;
         end else begin
            col_in = col_next[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_side_ff     <= 5'd8;
         tileset_count_ff <= 8'd1;
         tiles_per_row_ff <= 10'd1;
         state_ff         <= tmf_pkg::ST_IDLE;
         chk_valid_ff     <= 1'b0;
         cand_ff          <= '1;
         col_ff           <= '0;
         found_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         tile_side_ff     <= tile_side_in;
         tileset_count_ff <= tileset_count_in;
         tiles_per_row_ff <= tiles_per_row_in;
         state_ff         <= state_in;
         chk_valid_ff     <= chk_valid_in;
         cand_ff          <= cand_in;
         col_ff           <= col_in;
         found_ff         <= found_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff             <= iss_in;
      iss_addr_ff        <= iss_addr_in;
      chk_idx_ff         <= chk_idx_in;
      nt_ff              <= nt_in;
      posok_ff           <= posok_in;
      last_ff            <= last_in;
      rgb_ff             <= rgb_in;
      idx_ff             <= idx_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_match_index_ff <= rsp_match_index_in;
      rsp_row_end_ff     <= rsp_row_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_index_ff;
   assign rsp_row_end     = rsp_row_end_ff;

endmodule

FILE: rtl/tmf_ram.sv
module tmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32768,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
